>>> rtl/core/mpfb_pkg.sv
// Package for the page-organized monochrome framebuffer plot core.
// Holds field widths, operation and register codes, shared types and the pixel update function.
// Depends on nothing; every other file in rtl/core uses it by scoped names.
package mpfb_pkg;

   localparam int IDX_W      = 13;
   localparam int COORD_W    = 7;
   localparam int INDEX_W    = 10;
   localparam int BYTE_W     = 8;
   localparam int WIDTH_W    = 8;
   localparam int HEIGHT_W   = 7;
   localparam int OP_W       = 2;
   localparam int PAGE_W     = 5;
   localparam int BIT_W      = 3;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_SEL_W  = 2;

   localparam logic [OP_W-1:0] OP_NONE   = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
   localparam logic [OP_W-1:0] OP_SET    = 2'd2;
   localparam logic [OP_W-1:0] OP_TOGGLE = 2'd3;

   localparam logic KIND_PLOT = 1'b0;
   localparam logic KIND_READ = 1'b1;

   localparam logic [REG_SEL_W-1:0] REG_PORTRAIT = 2'd0;
   localparam logic [REG_SEL_W-1:0] REG_WIDTH    = 2'd1;
   localparam logic [REG_SEL_W-1:0] REG_HEIGHT   = 2'd2;

   localparam logic                RESET_PORTRAIT = 1'b0;
   localparam logic [WIDTH_W-1:0]  RESET_WIDTH    = 8'd128;
   localparam logic [HEIGHT_W-1:0] RESET_HEIGHT   = 7'd64;

   typedef struct packed {
      logic                portrait;
      logic [WIDTH_W-1:0]  width;
      logic [HEIGHT_W-1:0] height;
   } cfg_type;

   typedef struct packed {
      logic                kind;
      logic [COORD_W-1:0]  coord_x;
      logic [COORD_W-1:0]  coord_y;
      logic [OP_W-1:0]     pixel_op;
      logic [INDEX_W-1:0]  read_index;
   } req_type;

   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] index;
      logic [BIT_W-1:0] bit_sel;
   } loc_type;

   function automatic logic [BYTE_W-1:0] apply_op(input logic [BYTE_W-1:0] value,
                                                  input logic [BIT_W-1:0]  bit_sel,
                                                  input logic [OP_W-1:0]   op);
      logic [BYTE_W-1:0] mask;
      logic [BYTE_W-1:0] result;
      mask = BYTE_W'(1) << bit_sel;
      case (op)
         OP_NONE:   result = value;
         OP_CLEAR:  result = value & ~mask;
         OP_SET:    result = value | mask;
         OP_TOGGLE: result = value ^ mask;
         default:   result = value;
      endcase
      return result;
   endfunction

endpackage

>>> rtl/core/mpfb_csr.sv
// Configuration registers of the framebuffer plot core behind an APB-style port.
// Depends on mpfb_pkg for register codes, reset values and the configuration struct.
module mpfb_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [mpfb_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [mpfb_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [mpfb_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready,
   output mpfb_pkg::cfg_type                  cfg
);

   mpfb_pkg::cfg_type                 cfg_ff;
   mpfb_pkg::cfg_type                 cfg_in;
   logic [mpfb_pkg::REG_SEL_W-1:0]    reg_sel;
   logic                              wr_strobe;

   assign reg_sel    = csr_paddr[mpfb_pkg::CSR_ADDR_W-1:2];
   assign wr_strobe  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_strobe) begin
         case (reg_sel)
            mpfb_pkg::REG_PORTRAIT: cfg_in.portrait = csr_pwdata[0];
            mpfb_pkg::REG_WIDTH:    cfg_in.width    = csr_pwdata[mpfb_pkg::WIDTH_W-1:0];
            mpfb_pkg::REG_HEIGHT:   cfg_in.height   = csr_pwdata[mpfb_pkg::HEIGHT_W-1:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         mpfb_pkg::REG_PORTRAIT: csr_prdata = mpfb_pkg::CSR_DATA_W'(cfg_ff.portrait);
         mpfb_pkg::REG_WIDTH:    csr_prdata = mpfb_pkg::CSR_DATA_W'(cfg_ff.width);
         mpfb_pkg::REG_HEIGHT:   csr_prdata = mpfb_pkg::CSR_DATA_W'(cfg_ff.height);
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.portrait <= mpfb_pkg::RESET_PORTRAIT;
         cfg_ff.width    <= mpfb_pkg::RESET_WIDTH;
         cfg_ff.height   <= mpfb_pkg::RESET_HEIGHT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/core/mpfb_addr.sv
// Address unit: maps a plot coordinate or a read index to a canvas byte index and checks its range.
// Depends on mpfb_pkg for the item, configuration and location structs.
module mpfb_addr #(
   parameter int STORE_BYTES = 1024
) (
   input  mpfb_pkg::cfg_type  cfg,
   input  mpfb_pkg::req_type  req,
   output mpfb_pkg::loc_type  loc
);

   localparam logic [mpfb_pkg::IDX_W-1:0] STORE_LIMIT = mpfb_pkg::IDX_W'(STORE_BYTES);

   logic [mpfb_pkg::COORD_W-1:0] row;
   logic [mpfb_pkg::COORD_W-1:0] col;
   logic [mpfb_pkg::PAGE_W-1:0]  pages_used;
   logic [mpfb_pkg::IDX_W-1:0]   plot_index;
   logic [mpfb_pkg::IDX_W-1:0]   active_bytes;
   logic [mpfb_pkg::IDX_W-1:0]   read_index;
   logic                         plot_hit;
   logic                         read_hit;

   assign row = cfg.portrait ? req.coord_x : req.coord_y;
   assign col = cfg.portrait ? req.coord_y : req.coord_x;

   assign plot_index = mpfb_pkg::IDX_W'(row[mpfb_pkg::COORD_W-1:mpfb_pkg::BIT_W])
                       * mpfb_pkg::IDX_W'(cfg.width) + mpfb_pkg::IDX_W'(col);
   assign plot_hit   = (row < cfg.height) && ({1'b0, col} < cfg.width)
                       && (plot_index < STORE_LIMIT);

   assign pages_used   = mpfb_pkg::PAGE_W'(({1'b0, cfg.height} + 8'd7) >> mpfb_pkg::BIT_W);
   assign active_bytes = mpfb_pkg::IDX_W'(pages_used) * mpfb_pkg::IDX_W'(cfg.width);
   assign read_index   = mpfb_pkg::IDX_W'(req.read_index);
   assign read_hit     = (read_index < active_bytes) && (read_index < STORE_LIMIT);

   always_comb begin
      if (req.kind == mpfb_pkg::KIND_READ) begin
         loc.hit   = read_hit;
         loc.index = read_index;
      end else begin
         loc.hit   = plot_hit;
         loc.index = plot_index;
      end
      loc.bit_sel = row[mpfb_pkg::BIT_W-1:0];
   end

endmodule

>>> rtl/core/mpfb_canvas.sv
// Canvas byte store with one write port, one registered read port and a clearing sweep after reset.
// Depends on mpfb_pkg for the byte width.
module mpfb_canvas #(
   parameter int DEPTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [mpfb_pkg::BYTE_W-1:0]   wr_data,
   output logic [mpfb_pkg::BYTE_W-1:0]   rd_data,
   output logic                          clear_done
);

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW:0] DEPTH_C = (AW + 1)'(DEPTH);

   logic [mpfb_pkg::BYTE_W-1:0] mem [DEPTH];
   logic [mpfb_pkg::BYTE_W-1:0] rd_data_ff;
   logic [AW:0]                 clr_ff;
   logic [AW:0]                 clr_in;
   logic                        clearing;
   logic                        mem_we;
   logic [AW-1:0]               mem_wa;
   logic [mpfb_pkg::BYTE_W-1:0] mem_wd;

   assign clearing   = clr_ff < DEPTH_C;
   assign clear_done = !clearing;
   assign clr_in     = clearing ? clr_ff + 1'b1 : clr_ff;
   assign mem_we     = clearing || wr_en;
   assign mem_wa     = clearing ? clr_ff[AW-1:0] : wr_addr;
   assign mem_wd     = clearing ? '0 : wr_data;
   assign rd_data    = rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

>>> rtl/core/mono_page_framebuffer_plot_core.sv
// Top level of the page-organized monochrome framebuffer plot core.
// Depends on mpfb_pkg, mpfb_csr, mpfb_addr and mpfb_canvas.
//
// The req_ channel carries one item per handshake: a plot (kind 0) that updates
// one pixel with pixel_op, or a read (kind 1) that fetches the canvas byte at
// read_index. The rsp_ channel returns exactly one item for each request: the
// byte index, the byte after the operation and an out-of-range flag; a flagged
// item reports index and value zero. The csr_ port holds the portrait mode,
// panel width and panel height registers; write them only while no item is in
// flight.
// An item passes an input register, the canvas read register and the result
// register. One item is accepted per cycle unless the output stalls and the
// pipeline is full; back-to-back updates to the same byte are forwarded
// from the last write, so throughput does not depend on the address pattern.
// After reset a sweep clears all MAX_COLUMNS times MAX_PAGES bytes of the canvas
// (1024 by default), one byte per cycle, while req_ready stays low.
// When rsp_ready is low the pipeline fills its empty stages and then holds;
// req_ready falls once all three stages are full.
module mono_page_framebuffer_plot_core #(
   parameter int MAX_COLUMNS = 128,
   parameter int MAX_PAGES   = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_kind,
   input  logic [mpfb_pkg::COORD_W-1:0]       req_coord_x,
   input  logic [mpfb_pkg::COORD_W-1:0]       req_coord_y,
   input  logic [mpfb_pkg::OP_W-1:0]          req_pixel_op,
   input  logic [mpfb_pkg::INDEX_W-1:0]       req_read_index,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [mpfb_pkg::INDEX_W-1:0]       rsp_byte_index,
   output logic [mpfb_pkg::BYTE_W-1:0]        rsp_byte_value,
   output logic                               rsp_out_of_range,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [mpfb_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [mpfb_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [mpfb_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   localparam int STORE_BYTES = MAX_COLUMNS * MAX_PAGES;
   localparam int AW = $clog2(STORE_BYTES);
   localparam logic [mpfb_pkg::IDX_W-1:0] STORE_LIMIT = mpfb_pkg::IDX_W'(STORE_BYTES);

   mpfb_pkg::cfg_type                cfg;
   mpfb_pkg::loc_type                loc;
   mpfb_pkg::req_type                req_word;
   mpfb_pkg::req_type                s1_req_ff;
   logic                             s1_valid_ff;
   logic                             s2_valid_ff;
   logic                             s2_kind_ff;
   logic [mpfb_pkg::OP_W-1:0]        s2_op_ff;
   mpfb_pkg::loc_type                s2_loc_ff;
   logic                             fwd_valid_ff;
   logic [AW-1:0]                    fwd_addr_ff;
   logic [mpfb_pkg::BYTE_W-1:0]      fwd_data_ff;
   logic                             rsp_valid_ff;
   logic [mpfb_pkg::INDEX_W-1:0]     rsp_index_ff;
   logic [mpfb_pkg::BYTE_W-1:0]      rsp_value_ff;
   logic                             rsp_flag_ff;
   logic                             out_en;
   logic                             s2_load;
   logic                             s1_load;
   logic                             accept;
   logic                             clear_done;
   logic [AW-1:0]                    s2_addr;
   logic [mpfb_pkg::BYTE_W-1:0]      rd_data;
   logic [mpfb_pkg::BYTE_W-1:0]      base_byte;
   logic [mpfb_pkg::BYTE_W-1:0]      new_byte;
   logic                             s2_write;

   mpfb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mpfb_addr #(
      .STORE_BYTES (STORE_BYTES)
   ) u_addr (
      .cfg (cfg),
      .req (s1_req_ff),
      .loc (loc)
   );

   mpfb_canvas #(
      .DEPTH (STORE_BYTES)
   ) u_canvas (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (s2_load),
      .rd_addr    (loc.index[AW-1:0]),
      .wr_en      (s2_write),
      .wr_addr    (s2_addr),
      .wr_data    (new_byte),
      .rd_data    (rd_data),
      .clear_done (clear_done)
   );

   assign out_en    = !rsp_valid_ff || rsp_ready;
   assign s2_load   = !s2_valid_ff || out_en;
   assign s1_load   = !s1_valid_ff || s2_load;
   assign req_ready = s1_load && clear_done;
   assign accept    = req_valid && req_ready;

   assign req_word.kind       = req_kind;
   assign req_word.coord_x    = req_coord_x;
   assign req_word.coord_y    = req_coord_y;
   assign req_word.pixel_op   = req_pixel_op;
   assign req_word.read_index = req_read_index;

   assign s2_addr   = s2_loc_ff.index[AW-1:0];
   assign base_byte = (fwd_valid_ff && (fwd_addr_ff == s2_addr)) ? fwd_data_ff : rd_data;
   assign new_byte  = (s2_kind_ff == mpfb_pkg::KIND_PLOT)
                      ? mpfb_pkg::apply_op(base_byte, s2_loc_ff.bit_sel, s2_op_ff)
                      : base_byte;
   assign s2_write  = s2_valid_ff && out_en && s2_loc_ff.hit
                      && (s2_kind_ff == mpfb_pkg::KIND_PLOT);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= accept;
         end
         if (s2_load) begin
            s2_valid_ff  <= s1_valid_ff;
            fwd_valid_ff <= s2_write;
         end
         if (out_en) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_req_ff <= req_word;
      end
      if (s2_load) begin
         s2_kind_ff  <= s1_req_ff.kind;
         s2_op_ff    <= s1_req_ff.pixel_op;
         s2_loc_ff   <= loc;
         fwd_addr_ff <= s2_addr;
         fwd_data_ff <= new_byte;
      end
      if (out_en) begin
         rsp_index_ff <= s2_loc_ff.hit ? s2_loc_ff.index[mpfb_pkg::INDEX_W-1:0] : '0;
         rsp_value_ff <= s2_loc_ff.hit ? new_byte : '0;
         rsp_flag_ff  <= !s2_loc_ff.hit;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_byte_index   = rsp_index_ff;
   assign rsp_byte_value   = rsp_value_ff;
   assign rsp_out_of_range = rsp_flag_ff;

`ifndef NO_ASSERTIONS
   a_clear_blocks_input: assert property (@(posedge clock) disable iff (reset)
      !clear_done |-> !req_ready)
      else $error("Item accepted while the canvas is being cleared.");

   a_flagged_result_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> (rsp_byte_index == '0) && (rsp_byte_value == '0))
      else $error("Out-of-range item reports a nonzero index or value.");

   a_write_in_store: assert property (@(posedge clock) disable iff (reset)
      s2_write |-> (s2_loc_ff.index < STORE_LIMIT))
      else $error("Canvas write outside the store.");

   a_result_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s2_valid_ff))
      else $error("Result appeared without an item in the update stage.");
`endif

endmodule
